// ===== design/cll_pkg.sv =====
// shared types and constants of the calculator language lexer
// character classes, token kinds, fault codes and the result record
// no dependencies
package cll_pkg;

  localparam int unsigned TEXT_W     = 32;
  localparam int unsigned LINE_OUT_W = 24;
  localparam int unsigned TDATA_W    = 2 * TEXT_W + LINE_OUT_W + 8;
  localparam int unsigned TUSER_W    = 8;
  localparam int unsigned QDEPTH     = 4;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  typedef enum logic [5:0] {
    TK_END, TK_NL, TK_NUM, TK_ID, TK_STR,
    TK_PLUS, TK_MINUS, TK_MUL, TK_DIV, TK_MOD, TK_POW,
    TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK, TK_LBRACE, TK_RBRACE,
    TK_SEMI, TK_COMMA, TK_ASSIGN,
    TK_ADD_EQ, TK_SUB_EQ, TK_MUL_EQ, TK_DIV_EQ, TK_MOD_EQ, TK_POW_EQ,
    TK_EQ, TK_NE, TK_LT, TK_LE, TK_GT, TK_GE,
    TK_AND, TK_OR, TK_NOT, TK_INC, TK_DEC, TK_DOT
  } tok_e;

  typedef enum logic [1:0] {
    FLT_NONE, FLT_ILLEGAL, FLT_AMP, FLT_BAR
  } fault_e;

  typedef enum logic [3:0] {
    CLS_ILLEGAL, CLS_NL, CLS_BLANK, CLS_HASH, CLS_QUOTE, CLS_NUMSTART,
    CLS_DOT, CLS_LOWER, CLS_OP, CLS_OPEN, CLS_CLOSE, CLS_PUNCT, CLS_BSLASH
  } cls_e;

  typedef struct packed {
    logic       end_flag;
    logic [7:0] ch;
    cls_e       cls;
    tok_e       kind;
    tok_e       eq_kind;
    logic       digit;
    logic       upper;
    logic       lower;
  } cls_info_t;

  typedef struct packed {
    tok_e                  kind;
    logic [TEXT_W-1:0]     start;
    logic [TEXT_W-1:0]     len;
    logic [LINE_OUT_W-1:0] line;
    fault_e                fault;
    logic [7:0]            fchar;
    logic                  last;
  } res_t;

endpackage

// ===== design/cll_front.sv =====
// front end: takes source bytes, classifies them and numbers their offsets
// depends on cll_pkg
module cll_front #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_char_i,
  input  logic                  in_end_i,
  output logic                  in_ready_o,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output cll_pkg::cls_info_t    push_info_o,
  output logic [POS_WIDTH-1:0]  push_pos_o
);
  import cll_pkg::*;

  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic                 accept;
  cls_info_t            info;
  logic [7:0]           c;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;
  assign c            = in_char_i;

  always_comb begin
    info          = '0;
    info.end_flag = in_end_i;
    info.ch       = c;
    info.digit    = (c >= "0") && (c <= "9");
    info.upper    = (c >= "A") && (c <= "Z");
    info.lower    = (c >= "a") && (c <= "z");
    info.cls      = CLS_ILLEGAL;
    info.kind     = TK_END;
    info.eq_kind  = TK_END;
    if (info.digit || info.upper) begin
      info.cls = CLS_NUMSTART;
    end else if (info.lower) begin
      info.cls = CLS_LOWER;
    end else begin
      unique case (c)
        CH_NL:                  info.cls = CLS_NL;
        CH_SPACE, CH_TAB, CH_CR: info.cls = CLS_BLANK;
        CH_HASH:                info.cls = CLS_HASH;
        CH_QUOTE:               info.cls = CLS_QUOTE;
        CH_DOT:                 info.cls = CLS_DOT;
        CH_BSLASH:              info.cls = CLS_BSLASH;
        CH_PLUS:  begin info.cls = CLS_OP; info.kind = TK_PLUS;   info.eq_kind = TK_ADD_EQ; end
        CH_MINUS: begin info.cls = CLS_OP; info.kind = TK_MINUS;  info.eq_kind = TK_SUB_EQ; end
        CH_STAR:  begin info.cls = CLS_OP; info.kind = TK_MUL;    info.eq_kind = TK_MUL_EQ; end
        CH_SLASH: begin info.cls = CLS_OP; info.kind = TK_DIV;    info.eq_kind = TK_DIV_EQ; end
        "%":      begin info.cls = CLS_OP; info.kind = TK_MOD;    info.eq_kind = TK_MOD_EQ; end
        "^":      begin info.cls = CLS_OP; info.kind = TK_POW;    info.eq_kind = TK_POW_EQ; end
        CH_EQ:    begin info.cls = CLS_OP; info.kind = TK_ASSIGN; info.eq_kind = TK_EQ;     end
        "!":      begin info.cls = CLS_OP; info.kind = TK_NOT;    info.eq_kind = TK_NE;     end
        "<":      begin info.cls = CLS_OP; info.kind = TK_LT;     info.eq_kind = TK_LE;     end
        ">":      begin info.cls = CLS_OP; info.kind = TK_GT;     info.eq_kind = TK_GE;     end
        CH_AMP, CH_BAR:         info.cls = CLS_OP;
        "(":      begin info.cls = CLS_OPEN;  info.kind = TK_LPAREN; end
        "[":      begin info.cls = CLS_OPEN;  info.kind = TK_LBRACK; end
        ")":      begin info.cls = CLS_CLOSE; info.kind = TK_RPAREN; end
        "]":      begin info.cls = CLS_CLOSE; info.kind = TK_RBRACK; end
        "{":      begin info.cls = CLS_PUNCT; info.kind = TK_LBRACE; end
        "}":      begin info.cls = CLS_PUNCT; info.kind = TK_RBRACE; end
        ";":      begin info.cls = CLS_PUNCT; info.kind = TK_SEMI;   end
        ",":      begin info.cls = CLS_PUNCT; info.kind = TK_COMMA;  end
        default:  info.cls = CLS_ILLEGAL;
      endcase
    end
  end

  assign push_info_o = info;
  assign push_pos_o  = pos_q;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (in_end_i) begin
        pos_d = '0;
      end else if (pos_q != '1) begin
        pos_d = pos_q + POS_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== design/cll_queue.sv =====
// short queue of classified bytes between front and back end
// no dependencies
module cll_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             wr_fire, rd_fire;

  assign wr_ready_o = (count_q != CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (rd_fire) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (wr_fire && !rd_fire) begin
        count_q <= count_q + CW'(1);
      end else if (rd_fire && !wr_fire) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count above depth");

  a_held_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_o && !rd_ready_i) |=> rd_valid_o)
    else $error("queue lost an entry that was not read");

endmodule

// ===== design/cll_back.sv =====
// back end: lexer state machine and result output stage
// depends on cll_pkg; fed from cll_queue
module cll_back #(
  parameter int unsigned POS_WIDTH  = 32,
  parameter int unsigned LINE_WIDTH = 24,
  parameter int unsigned NEST_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          hd_valid_i,
  output logic                          hd_ready_o,
  input  cll_pkg::cls_info_t            hd_info_i,
  input  logic [POS_WIDTH-1:0]          hd_pos_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cll_pkg::res_t                 out_res_o
);
  import cll_pkg::*;

  typedef enum logic [3:0] {
    M_NORMAL, M_NUMBER, M_IDENT, M_STRING, M_LCOMMENT,
    M_BCOMMENT, M_BSTAR, M_DOT, M_BSLASH, M_OP
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [7:0]            held_q, held_d;
  tok_e                  sk_q, sk_d, ek_q, ek_d;
  logic [NEST_WIDTH-1:0] depth_q, depth_d;
  logic [LINE_WIDTH-1:0] line_q, line_d, tline_q, tline_d, line_inc;
  logic [POS_WIDTH-1:0]  begin_q, begin_d, len;
  res_t                  out_q, pend_q;
  logic                  out_valid_q, pend_valid_q;

  res_t       a, b, fo, r0, r1;
  logic       a_v, b_v, do_norm, numc, any, slot_free, pop;
  logic [7:0] ch;
  cls_info_t  hd;

  function automatic res_t mk(tok_e k, logic [POS_WIDTH-1:0] s, logic [POS_WIDTH-1:0] l,
                              logic [LINE_WIDTH-1:0] ln, fault_e f, logic [7:0] fc);
    res_t r;
    r.kind  = k;
    r.start = TEXT_W'(s);
    r.len   = TEXT_W'(l);
    r.line  = LINE_OUT_W'(ln);
    r.fault = f;
    r.fchar = fc;
    r.last  = 1'b0;
    return r;
  endfunction

  assign hd       = hd_info_i;
  assign ch       = hd.ch;
  assign len      = hd_pos_i - begin_q;
  assign line_inc = (line_q != '1) ? line_q + LINE_WIDTH'(1) : line_q;
  assign numc     = hd.digit || hd.upper || (ch == CH_DOT);

  // lone operator with no continuation
  always_comb begin
    if (held_q == CH_AMP) begin
      fo = mk(TK_END, begin_q, '0, line_q, FLT_AMP, CH_AMP);
    end else if (held_q == CH_BAR) begin
      fo = mk(TK_END, begin_q, '0, line_q, FLT_BAR, CH_BAR);
    end else begin
      fo = mk(sk_q, begin_q, '0, tline_q, FLT_NONE, '0);
    end
  end

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    sk_d    = sk_q;
    ek_d    = ek_q;
    depth_d = depth_q;
    line_d  = line_q;
    begin_d = begin_q;
    tline_d = tline_q;
    a_v     = 1'b0;
    b_v     = 1'b0;
    a       = mk(TK_END, hd_pos_i, '0, line_q, FLT_NONE, '0);
    b       = a;
    do_norm = 1'b0;
    if (hd.end_flag) begin
      unique case (mode_q)
        M_NUMBER: begin a_v = 1'b1; a = mk(TK_NUM, begin_q, len, tline_q, FLT_NONE, '0); end
        M_IDENT:  begin a_v = 1'b1; a = mk(TK_ID, begin_q, len, tline_q, FLT_NONE, '0); end
        M_STRING: begin a_v = 1'b1; a = mk(TK_STR, begin_q, len, line_q, FLT_NONE, '0); end
        M_DOT:    begin a_v = 1'b1; a = mk(TK_DOT, begin_q, '0, tline_q, FLT_NONE, '0); end
        M_BSLASH: begin
          a_v = 1'b1;
          a   = mk(TK_END, begin_q, '0, line_q, FLT_ILLEGAL, CH_BSLASH);
        end
        M_OP:     begin a_v = 1'b1; a = fo; end
        default:  a_v = 1'b0;
      endcase
      b_v     = 1'b1;
      b       = mk(TK_END, hd_pos_i, '0, line_q, FLT_NONE, '0);
      mode_d  = M_NORMAL;
      held_d  = '0;
      sk_d    = TK_END;
      ek_d    = TK_END;
      depth_d = '0;
      line_d  = LINE_WIDTH'(1);
      begin_d = '0;
      tline_d = LINE_WIDTH'(1);
    end else begin
      do_norm = 1'b1;
      unique case (mode_q)
        M_NUMBER: begin
          if (numc) begin
            do_norm = 1'b0;
          end else begin
            a_v = 1'b1;
            a   = mk(TK_NUM, begin_q, len, tline_q, FLT_NONE, '0);
          end
        end
        M_IDENT: begin
          if (hd.lower || hd.digit || ch == CH_UNDER) begin
            do_norm = 1'b0;
          end else begin
            a_v = 1'b1;
            a   = mk(TK_ID, begin_q, len, tline_q, FLT_NONE, '0);
          end
        end
        M_STRING: begin
          do_norm = 1'b0;
          if (ch == CH_QUOTE) begin
            a_v    = 1'b1;
            a      = mk(TK_STR, begin_q, len, line_q, FLT_NONE, '0);
            mode_d = M_NORMAL;
          end else if (ch == CH_NL) begin
            line_d = line_inc;
          end
        end
        M_LCOMMENT: begin
          if (ch != CH_NL) begin
            do_norm = 1'b0;
          end
        end
        M_BCOMMENT, M_BSTAR: begin
          do_norm = 1'b0;
          if (mode_q == M_BSTAR && ch == CH_SLASH) begin
            mode_d = M_NORMAL;
          end else begin
            if (ch == CH_NL) begin
              line_d = line_inc;
            end
            mode_d = (ch == CH_STAR) ? M_BSTAR : M_BCOMMENT;
          end
        end
        M_DOT: begin
          if (hd.digit || hd.upper) begin
            do_norm = 1'b0;
            mode_d  = M_NUMBER;
          end else begin
            a_v = 1'b1;
            a   = mk(TK_DOT, begin_q, '0, tline_q, FLT_NONE, '0);
          end
        end
        M_BSLASH: begin
          if (ch == CH_NL) begin
            do_norm = 1'b0;
            line_d  = line_inc;
            mode_d  = M_NORMAL;
          end else begin
            a_v = 1'b1;
            a   = mk(TK_END, begin_q, '0, line_q, FLT_ILLEGAL, CH_BSLASH);
          end
        end
        M_OP: begin
          priority if (held_q == CH_SLASH && ch == CH_STAR) begin
            do_norm = 1'b0;
            mode_d  = M_BCOMMENT;
          end else if ((held_q == CH_PLUS || held_q == CH_MINUS) && ch == held_q) begin
            do_norm = 1'b0;
            a_v     = 1'b1;
            a       = mk((held_q == CH_PLUS) ? TK_INC : TK_DEC, begin_q, '0, tline_q,
                         FLT_NONE, '0);
            mode_d  = M_NORMAL;
          end else if ((held_q == CH_AMP || held_q == CH_BAR) && ch == held_q) begin
            do_norm = 1'b0;
            a_v     = 1'b1;
            a       = mk((held_q == CH_AMP) ? TK_AND : TK_OR, begin_q, '0, tline_q,
                         FLT_NONE, '0);
            mode_d  = M_NORMAL;
          end else if (ch == CH_EQ && ek_q != TK_END) begin
            do_norm = 1'b0;
            a_v     = 1'b1;
            a       = mk(ek_q, begin_q, '0, tline_q, FLT_NONE, '0);
            mode_d  = M_NORMAL;
          end else begin
            a_v = 1'b1;
            a   = fo;
          end
        end
        default: do_norm = 1'b1;
      endcase
    end

    if (do_norm) begin
      mode_d  = M_NORMAL;
      begin_d = hd_pos_i;
      tline_d = line_q;
      unique case (hd.cls)
        CLS_BSLASH:   mode_d = M_BSLASH;
        CLS_NL: begin
          if (depth_q == '0) begin
            b_v = 1'b1;
            b   = mk(TK_NL, hd_pos_i, '0, line_q, FLT_NONE, '0);
          end
          line_d = line_inc;
        end
        CLS_BLANK:    mode_d = M_NORMAL;
        CLS_HASH:     mode_d = M_LCOMMENT;
        CLS_QUOTE: begin
          mode_d  = M_STRING;
          begin_d = (hd_pos_i != '1) ? hd_pos_i + POS_WIDTH'(1) : hd_pos_i;
        end
        CLS_NUMSTART: mode_d = M_NUMBER;
        CLS_DOT:      mode_d = M_DOT;
        CLS_LOWER:    mode_d = M_IDENT;
        CLS_OP: begin
          mode_d = M_OP;
          held_d = ch;
          sk_d   = hd.kind;
          ek_d   = hd.eq_kind;
        end
        CLS_OPEN: begin
          b_v = 1'b1;
          b   = mk(hd.kind, hd_pos_i, '0, line_q, FLT_NONE, '0);
          if (depth_q != '1) begin
            depth_d = depth_q + NEST_WIDTH'(1);
          end
        end
        CLS_CLOSE: begin
          b_v = 1'b1;
          b   = mk(hd.kind, hd_pos_i, '0, line_q, FLT_NONE, '0);
          if (depth_q != '0) begin
            depth_d = depth_q - NEST_WIDTH'(1);
          end
        end
        CLS_PUNCT: begin
          b_v = 1'b1;
          b   = mk(hd.kind, hd_pos_i, '0, line_q, FLT_NONE, '0);
        end
        default: begin
          b_v = 1'b1;
          b   = mk(TK_END, hd_pos_i, '0, line_q, FLT_ILLEGAL, ch);
        end
      endcase
    end
  end

  always_comb begin
    r0      = a_v ? a : b;
    r0.last = !(a_v && b_v);
    r1      = b;
    r1.last = 1'b1;
  end

  assign any         = a_v || b_v;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop         = hd_valid_i && !pend_valid_q && (slot_free || !any);
  assign hd_ready_o  = !pend_valid_q && (slot_free || !any);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_NORMAL;
      held_q       <= '0;
      sk_q         <= TK_END;
      ek_q         <= TK_END;
      depth_q      <= '0;
      line_q       <= LINE_WIDTH'(1);
      begin_q      <= '0;
      tline_q      <= LINE_WIDTH'(1);
      out_q        <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mode_q  <= mode_d;
        held_q  <= held_d;
        sk_q    <= sk_d;
        ek_q    <= ek_d;
        depth_q <= depth_d;
        line_q  <= line_d;
        begin_q <= begin_d;
        tline_q <= tline_d;
      end
      if (slot_free) begin
        if (pend_valid_q) begin
          out_q        <= pend_q;
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else if (pop && any) begin
          out_q       <= r0;
          out_valid_q <= 1'b1;
          if (a_v && b_v) begin
            pend_q       <= r1;
            pend_valid_q <= 1'b1;
          end
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("second result held without a first one in the output stage");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && hd.end_flag) |=>
      (mode_q == M_NORMAL && depth_q == '0 && line_q == LINE_WIDTH'(1)))
    else $error("scanner state not cleared after end of text");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q != '0) && (tline_q != '0))
    else $error("line counter reached zero");

endmodule

// ===== design/calculator_language_lexer_unit.sv =====
// Streaming lexer for a calculator language. Source bytes come in on the
// s_axis channel, one byte per request; a request with s_axis_tlast high is
// the end of the text (its data is ignored), flushes any open token, sends the
// end token and returns the scanner to its reset state for the next text.
// Tokens leave on m_axis, one per request; m_axis_tlast marks the final token
// caused by an input request. Token text is given by offset and length only.
// A taken byte passes the queue, then the back end output register, before its
// token is valid on m_axis. Throughput: one byte per cycle while each byte yields
// at most one token and the receiver is ready; a byte that closes a token and
// opens another yields two and holds the back end, which the four-entry queue
// absorbs. The rate is set by the single-result output register of the back end.
// Reset clears the queue, the offset, line and nesting counters and the
// output stage. When the receiver stalls, the output register holds its token,
// the queue fills, and s_axis_tready drops once four bytes are waiting.
// depends on cll_pkg, cll_front, cll_queue, cll_back
module calculator_language_lexer_unit #(
  parameter int unsigned POS_WIDTH  = 32,
  parameter int unsigned LINE_WIDTH = 24,
  parameter int unsigned NEST_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // char_in
  input  logic                        s_axis_tlast,  // end_of_input
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // text_start, text_length, line_number, fault_char
  output logic [cll_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [cll_pkg::TUSER_W-1:0] m_axis_tuser,  // token_kind, fault
  output logic                        m_axis_tlast   // last
);
  import cll_pkg::*;

  localparam int unsigned QW = POS_WIDTH + $bits(cls_info_t);

  logic                 f_valid, f_ready, q_valid, q_ready;
  cls_info_t            f_info, q_info;
  logic [POS_WIDTH-1:0] f_pos, q_pos;
  logic [QW-1:0]        q_data;
  res_t                 res;

  cll_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_char_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .push_valid_o(f_valid),
    .push_ready_i(f_ready),
    .push_info_o (f_info),
    .push_pos_o  (f_pos)
  );

  cll_queue #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i ({f_pos, f_info}),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (q_data)
  );

  assign q_info = q_data[$bits(cls_info_t)-1:0];
  assign q_pos  = q_data[QW-1:$bits(cls_info_t)];

  cll_back #(
    .POS_WIDTH (POS_WIDTH),
    .LINE_WIDTH(LINE_WIDTH),
    .NEST_WIDTH(NEST_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hd_valid_i (q_valid),
    .hd_ready_o (q_ready),
    .hd_info_i  (q_info),
    .hd_pos_i   (q_pos),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  assign m_axis_tdata = {res.fchar, res.line, res.len, res.start};
  assign m_axis_tuser = {res.fault, res.kind};
  assign m_axis_tlast = res.last;

endmodule

// ===== sim/cll_token_checker.sv =====
// token checker for the calculator language lexer testbench
// watches both stream channels, predicts tokens from accepted bytes, compares
// depends on cll_pkg
module cll_token_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         s_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [cll_pkg::TDATA_W-1:0]  m_tdata_i,
  input  logic [cll_pkg::TUSER_W-1:0]  m_tuser_i,
  input  logic                         m_tlast_i,
  input  logic                         end_check_i,
  output int unsigned                  fail_count_o = 0,
  output int unsigned                  pending_o = 0,
  output int unsigned                  checked_o = 0
);
  import cll_pkg::*;

  typedef enum logic [3:0] {
    SC_NORMAL, SC_NUMBER, SC_IDENT, SC_STRING, SC_LINE_CMT,
    SC_BLOCK_CMT, SC_BLOCK_STAR, SC_DOT, SC_BSLASH, SC_OP
  } scan_e;

  scan_e                 mode;
  logic [7:0]            held;
  logic [7:0]            depth;
  logic [LINE_OUT_W-1:0] line_cnt;
  logic [TEXT_W-1:0]     byte_pos;
  logic [TEXT_W-1:0]     tok_start;
  logic [LINE_OUT_W-1:0] tok_line;
  res_t                  token_q[$];
  logic                  end_done = 1'b0;

  task automatic report_mismatch(input string what);
    if (fail_count_o < 30) $display("MISMATCH at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic in_number(logic [7:0] c);
    return is_digit(c) || is_upper(c) || c == CH_DOT;
  endfunction

  function automatic tok_e op_kind(logic [7:0] c);
    case (c)
      CH_PLUS:  return TK_PLUS;
      CH_MINUS: return TK_MINUS;
      CH_STAR:  return TK_MUL;
      CH_SLASH: return TK_DIV;
      "%":      return TK_MOD;
      "^":      return TK_POW;
      CH_EQ:    return TK_ASSIGN;
      "!":      return TK_NOT;
      "<":      return TK_LT;
      ">":      return TK_GT;
      default:  return TK_END;
    endcase
  endfunction

  function automatic tok_e eq_op_kind(logic [7:0] c);
    case (c)
      CH_PLUS:  return TK_ADD_EQ;
      CH_MINUS: return TK_SUB_EQ;
      CH_STAR:  return TK_MUL_EQ;
      CH_SLASH: return TK_DIV_EQ;
      "%":      return TK_MOD_EQ;
      "^":      return TK_POW_EQ;
      CH_EQ:    return TK_EQ;
      "!":      return TK_NE;
      "<":      return TK_LE;
      ">":      return TK_GE;
      default:  return TK_END;
    endcase
  endfunction

  function automatic void add_token(tok_e k, logic [TEXT_W-1:0] start,
                                    logic [TEXT_W-1:0] len, logic [LINE_OUT_W-1:0] line,
                                    fault_e f, logic [7:0] fc);
    res_t r;
    r.kind  = k;
    r.start = start;
    r.len   = len;
    r.line  = line;
    r.fault = f;
    r.fchar = fc;
    r.last  = 1'b0;
    token_q.push_back(r);
  endfunction

  function automatic void add_plain(tok_e k, logic [TEXT_W-1:0] start);
    add_token(k, start, '0, line_cnt, FLT_NONE, 8'h00);
  endfunction

  function automatic void bump_line();
    if (line_cnt != '1) line_cnt++;
  endfunction

  function automatic void lexer_reset();
    mode      = SC_NORMAL;
    held      = 8'h00;
    depth     = 8'h00;
    line_cnt  = LINE_OUT_W'(1);
    byte_pos  = '0;
    tok_start = '0;
    tok_line  = LINE_OUT_W'(1);
  endfunction

  function automatic void flush_op();
    if (held == CH_AMP) add_token(TK_END, tok_start, '0, line_cnt, FLT_AMP, CH_AMP);
    else if (held == CH_BAR) add_token(TK_END, tok_start, '0, line_cnt, FLT_BAR, CH_BAR);
    else add_token(op_kind(held), tok_start, '0, tok_line, FLT_NONE, 8'h00);
  endfunction

  function automatic void start_token(logic [7:0] c, logic [TEXT_W-1:0] p);
    mode      = SC_NORMAL;
    tok_start = p;
    tok_line  = line_cnt;
    if (c == CH_BSLASH) mode = SC_BSLASH;
    else if (c == CH_NL) begin
      if (depth == 0) add_plain(TK_NL, p);
      bump_line();
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) mode = SC_NORMAL;
    else if (c == CH_HASH) mode = SC_LINE_CMT;
    else if (c == CH_QUOTE) begin
      mode      = SC_STRING;
      tok_start = (p != '1) ? p + TEXT_W'(1) : p;
    end else if (is_digit(c) || is_upper(c)) mode = SC_NUMBER;
    else if (c == CH_DOT) mode = SC_DOT;
    else if (is_lower(c)) mode = SC_IDENT;
    else if (op_kind(c) != TK_END || c == CH_AMP || c == CH_BAR) begin
      mode = SC_OP;
      held = c;
    end else begin
      case (c)
        "(", "[": begin
          add_plain((c == "(") ? TK_LPAREN : TK_LBRACK, p);
          if (depth != '1) depth++;
        end
        ")", "]": begin
          add_plain((c == ")") ? TK_RPAREN : TK_RBRACK, p);
          if (depth != 0) depth--;
        end
        "{": add_plain(TK_LBRACE, p);
        "}": add_plain(TK_RBRACE, p);
        ";": add_plain(TK_SEMI, p);
        ",": add_plain(TK_COMMA, p);
        default: add_token(TK_END, p, '0, line_cnt, FLT_ILLEGAL, c);
      endcase
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic [TEXT_W-1:0] p);
    logic restart;
    restart = 1'b1;
    case (mode)
      SC_NUMBER: begin
        if (in_number(c)) restart = 1'b0;
        else add_token(TK_NUM, tok_start, p - tok_start, tok_line, FLT_NONE, 8'h00);
      end
      SC_IDENT: begin
        if (is_lower(c) || is_digit(c) || c == CH_UNDER) restart = 1'b0;
        else add_token(TK_ID, tok_start, p - tok_start, tok_line, FLT_NONE, 8'h00);
      end
      SC_STRING: begin
        restart = 1'b0;
        if (c == CH_QUOTE) begin
          add_token(TK_STR, tok_start, p - tok_start, line_cnt, FLT_NONE, 8'h00);
          mode = SC_NORMAL;
        end else if (c == CH_NL) bump_line();
      end
      SC_LINE_CMT: begin
        if (c != CH_NL) restart = 1'b0;
      end
      SC_BLOCK_CMT, SC_BLOCK_STAR: begin
        restart = 1'b0;
        if (mode == SC_BLOCK_STAR && c == CH_SLASH) mode = SC_NORMAL;
        else begin
          if (c == CH_NL) bump_line();
          mode = (c == CH_STAR) ? SC_BLOCK_STAR : SC_BLOCK_CMT;
        end
      end
      SC_DOT: begin
        if (in_number(c) && c != CH_DOT) begin
          mode    = SC_NUMBER;
          restart = 1'b0;
        end else add_token(TK_DOT, tok_start, '0, tok_line, FLT_NONE, 8'h00);
      end
      SC_BSLASH: begin
        if (c == CH_NL) begin
          bump_line();
          mode    = SC_NORMAL;
          restart = 1'b0;
        end else add_token(TK_END, tok_start, '0, line_cnt, FLT_ILLEGAL, CH_BSLASH);
      end
      SC_OP: begin
        if (held == CH_SLASH && c == CH_STAR) begin
          mode    = SC_BLOCK_CMT;
          restart = 1'b0;
        end else if ((held == CH_PLUS || held == CH_MINUS) && c == held) begin
          add_token((held == CH_PLUS) ? TK_INC : TK_DEC, tok_start, '0, tok_line,
                    FLT_NONE, 8'h00);
          mode    = SC_NORMAL;
          restart = 1'b0;
        end else if ((held == CH_AMP || held == CH_BAR) && c == held) begin
          add_token((held == CH_AMP) ? TK_AND : TK_OR, tok_start, '0, tok_line,
                    FLT_NONE, 8'h00);
          mode    = SC_NORMAL;
          restart = 1'b0;
        end else if (c == CH_EQ && eq_op_kind(held) != TK_END) begin
          add_token(eq_op_kind(held), tok_start, '0, tok_line, FLT_NONE, 8'h00);
          mode    = SC_NORMAL;
          restart = 1'b0;
        end else flush_op();
      end
      default: restart = 1'b1;
    endcase
    if (restart) start_token(c, p);
  endfunction

  function automatic void flush_text();
    case (mode)
      SC_NUMBER: add_token(TK_NUM, tok_start, byte_pos - tok_start, tok_line, FLT_NONE, 8'h00);
      SC_IDENT:  add_token(TK_ID, tok_start, byte_pos - tok_start, tok_line, FLT_NONE, 8'h00);
      SC_STRING: add_token(TK_STR, tok_start, byte_pos - tok_start, line_cnt, FLT_NONE, 8'h00);
      SC_DOT:    add_token(TK_DOT, tok_start, '0, tok_line, FLT_NONE, 8'h00);
      SC_BSLASH: add_token(TK_END, tok_start, '0, line_cnt, FLT_ILLEGAL, CH_BSLASH);
      SC_OP:     flush_op();
      default:   mode = SC_NORMAL;
    endcase
    add_plain(TK_END, byte_pos);
  endfunction

  function automatic void predict_request(logic [7:0] c, logic eoi);
    int unsigned before_n;
    res_t r;
    before_n = token_q.size();
    if (eoi) begin
      flush_text();
      lexer_reset();
    end else begin
      scan_byte(c, byte_pos);
      if (byte_pos != '1) byte_pos++;
    end
    if (token_q.size() > before_n) begin
      r = token_q.pop_back();
      r.last = 1'b1;
      token_q.push_back(r);
    end
  endfunction

  task automatic check_token();
    res_t got;
    res_t want;
    got.kind  = tok_e'(m_tuser_i[5:0]);
    got.fault = fault_e'(m_tuser_i[7:6]);
    got.start = m_tdata_i[TEXT_W-1:0];
    got.len   = m_tdata_i[2*TEXT_W-1:TEXT_W];
    got.line  = m_tdata_i[2*TEXT_W+LINE_OUT_W-1:2*TEXT_W];
    got.fchar = m_tdata_i[TDATA_W-1:TDATA_W-8];
    got.last  = m_tlast_i;
    if (token_q.size() == 0) begin
      report_mismatch($sformatf("unexpected token kind %0d start %0d", got.kind, got.start));
    end else begin
      want = token_q.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                  checked_o, got.kind, want.kind));
      if (got.start != want.start)
        report_mismatch($sformatf("token %0d start %0d, expected %0d",
                                  checked_o, got.start, want.start));
      if (got.len != want.len)
        report_mismatch($sformatf("token %0d length %0d, expected %0d",
                                  checked_o, got.len, want.len));
      if (got.line != want.line)
        report_mismatch($sformatf("token %0d line %0d, expected %0d",
                                  checked_o, got.line, want.line));
      if (got.fault != want.fault)
        report_mismatch($sformatf("token %0d fault %0d, expected %0d",
                                  checked_o, got.fault, want.fault));
      if (got.fchar != want.fchar)
        report_mismatch($sformatf("token %0d fault char %0h, expected %0h",
                                  checked_o, got.fchar, want.fchar));
      if (got.last != want.last)
        report_mismatch($sformatf("token %0d last %0b, expected %0b",
                                  checked_o, got.last, want.last));
    end
    checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lexer_reset();
      token_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) predict_request(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_token();
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (token_q.size() != 0)
          report_mismatch($sformatf("%0d expected tokens never arrived", token_q.size()));
      end
    end
    pending_o = token_q.size();
  end

endmodule

// ===== sim/tb_calculator_language_lexer_unit.sv =====
// testbench top for the calculator language lexer
// drives source text with random gaps and output stalls, gives the verdict
// depends on cll_pkg, calculator_language_lexer_unit, cll_token_checker
module tb_calculator_language_lexer_unit;
  import cll_pkg::*;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [TUSER_W-1:0]  m_axis_tuser;
  logic                m_axis_tlast;
  logic                end_check = 1'b0;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         checked;

  int unsigned         bytes_sent = 0;
  int unsigned         text_count = 0;
  int unsigned         burst_left = 0;
  logic                quiet = 1'b0;
  rx_mode_e            rx_mode = RX_FREE;
  logic [7:0]          rx_pattern = 8'hFF;
  int unsigned         rx_left = 0;

  string op_list [35] = '{"+", "-", "*", "/", "%", "^", "(", ")", "[", "]", "{", "}",
                          ";", ",", "=", "+=", "-=", "*=", "/=", "%=", "^=", "==",
                          "!=", "<", "<=", ">", ">=", "&&", "||", "!", "++", "--",
                          ".", "&", "|"};

  calculator_language_lexer_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  cll_token_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .end_check_i (end_check),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_left    = $urandom_range(16, 96);
      rx_mode    = quiet ? RX_FREE : rx_mode_e'($urandom_range(0, 2));
      rx_pattern = 8'($urandom) | 8'h01;
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:   m_axis_tready = 1'b1;
      RX_RANDOM: m_axis_tready = ($urandom_range(0, 9) < 7);
      default: begin
        m_axis_tready = rx_pattern[0];
        rx_pattern    = {rx_pattern[0], rx_pattern[7:1]};
      end
    endcase
  end

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_text();
    send_byte(8'($urandom), 1'b1);
    text_count++;
  endtask

  // hold off until every expected token is out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] printable();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    return (c == CH_QUOTE) ? 8'h61 : c;
  endfunction

  task automatic send_lexeme();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        c = 8'($urandom_range(0, 36));
        send_byte((c < 10) ? 8'h30 + c : (c < 36) ? 8'h37 + c : CH_DOT, 1'b0);
      end
    end else if (pick < 30) begin
      send_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        c = 8'($urandom_range(0, 36));
        send_byte((c < 10) ? 8'h30 + c : (c < 36) ? 8'h57 + c : CH_UNDER, 1'b0);
      end
    end else if (pick < 50) begin
      send_text(op_list[$urandom_range(0, 34)]);
    end else if (pick < 58) begin
      c = 8'($urandom_range(0, 2));
      send_byte((c == 0) ? CH_SPACE : (c == 1) ? CH_TAB : CH_CR, 1'b0);
    end else if (pick < 66) begin
      send_byte(CH_NL, 1'b0);
    end else if (pick < 71) begin
      send_byte(CH_QUOTE, 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) send_byte(($urandom_range(0, 5) == 0) ? CH_NL : printable(), 1'b0);
      if ($urandom_range(0, 7) != 0) send_byte(CH_QUOTE, 1'b0);
    end else if (pick < 74) begin
      send_byte(CH_HASH, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) send_byte(printable(), 1'b0);
      send_byte(CH_NL, 1'b0);
    end else if (pick < 77) begin
      send_text("/*");
      n = $urandom_range(0, 8);
      repeat (n) begin
        c = 8'($urandom_range(0, 3));
        send_byte((c == 0) ? CH_STAR : (c == 1) ? CH_SLASH : (c == 2) ? CH_NL : printable(),
                  1'b0);
      end
      if ($urandom_range(0, 7) != 0) send_text("*/");
    end else if (pick < 80) begin
      send_byte(CH_BSLASH, 1'b0);
      send_byte(CH_NL, 1'b0);
    end else if (pick < 86) begin
      send_text(($urandom_range(0, 1) == 0) ? "(" : "[");
      n = $urandom_range(0, 3);
      repeat (n) send_byte(($urandom_range(0, 1) == 0) ? CH_NL : 8'h78, 1'b0);
      send_text(($urandom_range(0, 1) == 0) ? ")" : "]");
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int unsigned n;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // close at depth zero, illegal bytes, stray backslash, lone & and |, open string
    send_text(")");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_UNDER, 1'b0);
    send_byte(8'h0C, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_text("a&b|");
    send_byte(CH_QUOTE, 1'b0);
    send_text("s");
    end_text();
    send_text("/*x");
    end_text();
    end_text();
    send_text(".");
    end_text();
    send_text("+");
    end_text();
    drain();

    foreach (op_list[i]) begin
      send_text(op_list[i]);
      send_byte(CH_SPACE, 1'b0);
    end
    end_text();

    while (bytes_sent < 1650) begin
      quiet = ($urandom_range(0, 5) == 0);
      if (text_count == 12) begin
        // nesting counter saturates, so closing 255 levels reaches zero again
        repeat (270) send_text("(");
        send_byte(CH_NL, 1'b0);
        repeat (255) send_text(")");
        send_byte(CH_NL, 1'b0);
        end_text();
      end
      n = $urandom_range(1, 30);
      repeat (n) begin
        send_lexeme();
        if ($urandom_range(0, 2) == 0) send_byte(CH_SPACE, 1'b0);
      end
      end_text();
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (16) @(negedge clk_i);
    end_check = 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    $display("sent %0d requests in %0d texts, %0d tokens compared", bytes_sent, text_count,
             checked);
    $display("covered every operator, faults, comments, strings and nesting saturation");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
